/* design/vsc_pkg.sv */
`default_nettype none

package vsc_pkg;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic signed [1:0] ORDER_A_FIRST = -2'sd1;
  localparam logic signed [1:0] ORDER_EQUAL   = 2'sd0;
  localparam logic signed [1:0] ORDER_B_FIRST = 2'sd1;

  typedef struct packed {
    logic       which_string;
    logic [7:0] symbol;
    logic       has_symbol;
    logic       end_of_string;
  } vsc_in_t;

  typedef struct packed {
    logic signed [1:0] order;
    logic              overflow;
  } vsc_out_t;

  // Datapath to controller
  typedef struct packed {
    logic              completing;
    logic              end_a;
    logic              end_b;
    logic              digit_a;
    logic              digit_b;
    logic              zero_a;
    logic              zero_b;
    logic              less;
    logic              greater;
    logic signed [1:0] diff;
    logic              out_full;
  } vsc_status_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;
    logic              inc_a;
    logic              inc_b;
    logic              diff_clear;
    logic              diff_capture;
    logic              finish;
    logic signed [1:0] order;
  } vsc_cmd_t;

endpackage

`default_nettype wire

/* design/version_string_compare.sv */
// Load: one byte per cycle while in_stall is low; in_stall rises after the transaction
// that completes both strings and stays high through the comparison.
// Compare: each walk step is a registered buffer read, then an evaluate, with at most
// 2*(len_a + len_b) + 3 steps before the finish state is reached.
// The result sits in an output register; loading of the next pair overlaps its wait.
// Reset (rst, synchronous): clears lengths, flags and control; buffers are not cleared.
`default_nettype none

module version_string_compare #(
  parameter int MAX_LEN = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire vsc_pkg::vsc_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output vsc_pkg::vsc_out_t      out_data
);
  import vsc_pkg::*;

  vsc_cmd_t    cmd;
  vsc_status_t sts;

  vsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  vsc_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_complete_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.load && sts.completing |=> in_stall)
    else $error("input not blocked after completing transaction");

  a_finish_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(out_valid && out_stall))
    else $error("result overwrote a pending transaction");

  a_finish_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("result not presented after finish");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("output valid without finish");

endmodule

`default_nettype wire

/* design/vsc_dp.sv */
`default_nettype none

module vsc_dp #(
  parameter int MAX_LEN = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire vsc_pkg::vsc_in_t     in_data,
  input  wire vsc_pkg::vsc_cmd_t    cmd,
  input  wire logic                 out_stall,
  output vsc_pkg::vsc_status_t      sts,
  output logic                      out_valid,
  output vsc_pkg::vsc_out_t         out_data
);
  import vsc_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam logic [LW-1:0] LEN_FULL = LW'(MAX_LEN);

  logic [7:0]        mem_a [MAX_LEN];
  logic [7:0]        mem_b [MAX_LEN];
  logic [7:0]        q_a;
  logic [7:0]        q_b;
  logic [LW-1:0]     len_a;
  logic [LW-1:0]     len_b;
  logic [LW-1:0]     ptr_a;
  logic [LW-1:0]     ptr_b;
  logic              a_complete;
  logic              b_complete;
  logic              truncated;
  logic signed [1:0] diff;

  logic sel_a;
  logic sel_b;
  logic wr_a;
  logic wr_b;
  logic drop;

  assign sel_a = cmd.load && !in_data.which_string && !a_complete;
  assign sel_b = cmd.load && in_data.which_string && !b_complete;
  assign wr_a  = sel_a && in_data.has_symbol && (len_a != LEN_FULL);
  assign wr_b  = sel_b && in_data.has_symbol && (len_b != LEN_FULL);
  assign drop  = (sel_a && in_data.has_symbol && (len_a == LEN_FULL)) ||
                 (sel_b && in_data.has_symbol && (len_b == LEN_FULL));

  always_comb begin
    sts.completing = (a_complete || (!in_data.which_string && in_data.end_of_string)) &&
                     (b_complete || (in_data.which_string && in_data.end_of_string));
    sts.end_a    = ptr_a >= len_a;
    sts.end_b    = ptr_b >= len_b;
    sts.digit_a  = (q_a >= CHAR_ZERO) && (q_a <= CHAR_NINE);
    sts.digit_b  = (q_b >= CHAR_ZERO) && (q_b <= CHAR_NINE);
    sts.zero_a   = q_a == CHAR_ZERO;
    sts.zero_b   = q_b == CHAR_ZERO;
    sts.less     = q_a < q_b;
    sts.greater  = q_a > q_b;
    sts.diff     = diff;
    sts.out_full = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[len_a[AW-1:0]] <= in_data.symbol;
    end
    q_a <= mem_a[ptr_a[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[len_b[AW-1:0]] <= in_data.symbol;
    end
    q_b <= mem_b[ptr_b[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      len_a      <= '0;
      len_b      <= '0;
      ptr_a      <= '0;
      ptr_b      <= '0;
      a_complete <= 1'b0;
      b_complete <= 1'b0;
      truncated  <= 1'b0;
      diff       <= ORDER_EQUAL;
    end else begin
      if (wr_a) begin
        len_a <= len_a + LW'(1);
      end
      if (wr_b) begin
        len_b <= len_b + LW'(1);
      end
      if (drop) begin
        truncated <= 1'b1;
      end
      if (sel_a && in_data.end_of_string) begin
        a_complete <= 1'b1;
      end
      if (sel_b && in_data.end_of_string) begin
        b_complete <= 1'b1;
      end
      if (cmd.inc_a) begin
        ptr_a <= ptr_a + LW'(1);
      end
      if (cmd.inc_b) begin
        ptr_b <= ptr_b + LW'(1);
      end
      if (cmd.diff_clear) begin
        diff <= ORDER_EQUAL;
      end else if (cmd.diff_capture) begin
        diff <= sts.less ? ORDER_A_FIRST : ORDER_B_FIRST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.order    <= cmd.order;
      out_data.overflow <= truncated;
    end
  end

endmodule

`default_nettype wire

/* design/vsc_ctrl.sv */
`default_nettype none

module vsc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire vsc_pkg::vsc_status_t sts,
  output logic                      in_stall,
  output vsc_pkg::vsc_cmd_t         cmd
);
  import vsc_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MODE_PIECE,
    MODE_ZERO,
    MODE_DIGITS
  } mode_t;

  state_t            state;
  state_t            state_next;
  mode_t             mode;
  mode_t             mode_next;
  logic signed [1:0] res;
  logic signed [1:0] res_next;

  logic run_a;
  logic run_b;
  logic skip_a;
  logic skip_b;

  assign run_a  = !sts.end_a && sts.digit_a;
  assign run_b  = !sts.end_b && sts.digit_b;
  assign skip_a = !sts.end_a && sts.zero_a;
  assign skip_b = !sts.end_b && sts.zero_b;

  assign in_stall = state != ST_LOAD;

  always_comb begin
    state_next       = state;
    mode_next        = mode;
    res_next         = res;
    cmd.load         = 1'b0;
    cmd.inc_a        = 1'b0;
    cmd.inc_b        = 1'b0;
    cmd.diff_clear   = 1'b0;
    cmd.diff_capture = 1'b0;
    cmd.finish       = 1'b0;
    cmd.order        = res;
    case (state)
      ST_LOAD: begin
        cmd.load = in_valid;
        if (in_valid && sts.completing) begin
          state_next = ST_READ;
          mode_next  = MODE_PIECE;
        end
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = ST_READ;
        case (mode)
          MODE_PIECE: begin
            if (sts.end_a || sts.end_b) begin
              state_next = ST_FINISH;
              res_next   = (sts.end_a && sts.end_b) ? ORDER_EQUAL :
                           (sts.end_a ? ORDER_A_FIRST : ORDER_B_FIRST);
            end else if (sts.digit_a && sts.digit_b) begin
              mode_next = MODE_ZERO;
            end else if (sts.digit_a || (!sts.digit_b && sts.less)) begin
              state_next = ST_FINISH;
              res_next   = ORDER_A_FIRST;
            end else if (sts.digit_b || sts.greater) begin
              state_next = ST_FINISH;
              res_next   = ORDER_B_FIRST;
            end else begin
              cmd.inc_a = 1'b1;
              cmd.inc_b = 1'b1;
            end
          end
          MODE_ZERO: begin
            // drop leading zeros of each run independently
            if (skip_a || skip_b) begin
              cmd.inc_a = skip_a;
              cmd.inc_b = skip_b;
            end else begin
              mode_next      = MODE_DIGITS;
              cmd.diff_clear = 1'b1;
            end
          end
          MODE_DIGITS: begin
            if (run_a && run_b) begin
              cmd.inc_a        = 1'b1;
              cmd.inc_b        = 1'b1;
              cmd.diff_capture = (sts.diff == ORDER_EQUAL) && (sts.less || sts.greater);
            end else if (run_a) begin
              state_next = ST_FINISH;
              res_next   = ORDER_B_FIRST;
            end else if (run_b) begin
              state_next = ST_FINISH;
              res_next   = ORDER_A_FIRST;
            end else if (sts.diff != ORDER_EQUAL) begin
              state_next = ST_FINISH;
              res_next   = sts.diff;
            end else begin
              mode_next = MODE_PIECE;
            end
          end
          default: begin
            mode_next = MODE_PIECE;
          end
        endcase
      end
      ST_FINISH: begin
        // hold the result until the output register can take it
        if (!sts.out_full) begin
          cmd.finish = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      mode  <= MODE_PIECE;
      res   <= ORDER_EQUAL;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      res   <= res_next;
    end
  end

endmodule

`default_nettype wire

/* dv/version_string_compare_checker.sv */
module version_string_compare_checker #(
  parameter int MAX_LEN = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  vsc_pkg::vsc_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  vsc_pkg::vsc_out_t out_data,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import vsc_pkg::*;

  logic [7:0] str_a [MAX_LEN];
  logic [7:0] str_b [MAX_LEN];
  int         len_a;
  int         len_b;
  logic       done_a;
  logic       done_b;
  logic       clipped;
  vsc_out_t   expected_orders [$];
  vsc_out_t   due;

  function automatic logic is_num(input logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  // Walk both strings piece by piece: digit runs as numbers, other bytes unsigned.
  function automatic logic signed [1:0] natural_order();
    int i;
    int j;
    int ia;
    int ib;
    int k;
    i = 0;
    j = 0;
    while (1) begin
      if (i >= len_a && j >= len_b) return ORDER_EQUAL;
      if (i >= len_a) return ORDER_A_FIRST;
      if (j >= len_b) return ORDER_B_FIRST;
      if (is_num(str_a[i]) && is_num(str_b[j])) begin
        ia = i;
        ib = j;
        while (i < len_a && is_num(str_a[i])) i++;
        while (j < len_b && is_num(str_b[j])) j++;
        while (ia < i && str_a[ia] == CHAR_ZERO) ia++;
        while (ib < j && str_b[ib] == CHAR_ZERO) ib++;
        if (i - ia < j - ib) return ORDER_A_FIRST;
        if (i - ia > j - ib) return ORDER_B_FIRST;
        for (k = 0; k < i - ia; k++) begin
          if (str_a[ia + k] < str_b[ib + k]) return ORDER_A_FIRST;
          if (str_a[ia + k] > str_b[ib + k]) return ORDER_B_FIRST;
        end
      end else if (is_num(str_a[i])) begin
        return ORDER_A_FIRST;
      end else if (is_num(str_b[j])) begin
        return ORDER_B_FIRST;
      end else begin
        if (str_a[i] < str_b[j]) return ORDER_A_FIRST;
        if (str_a[i] > str_b[j]) return ORDER_B_FIRST;
        i++;
        j++;
      end
    end
    return ORDER_EQUAL;
  endfunction

  task automatic clear_pair();
    len_a = 0;
    len_b = 0;
    done_a = 1'b0;
    done_b = 1'b0;
    clipped = 1'b0;
  endtask

  task automatic fold_transaction(input vsc_in_t t);
    vsc_out_t r;
    if (!t.which_string && !done_a) begin
      if (t.has_symbol) begin
        if (len_a < MAX_LEN) begin
          str_a[len_a] = t.symbol;
          len_a++;
        end else begin
          clipped = 1'b1;
        end
      end
      if (t.end_of_string) done_a = 1'b1;
    end else if (t.which_string && !done_b) begin
      if (t.has_symbol) begin
        if (len_b < MAX_LEN) begin
          str_b[len_b] = t.symbol;
          len_b++;
        end else begin
          clipped = 1'b1;
        end
      end
      if (t.end_of_string) done_b = 1'b1;
    end
    if (done_a && done_b) begin
      r.order = natural_order();
      r.overflow = clipped;
      expected_orders.push_back(r);
      clear_pair();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_pair();
      expected_orders.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_orders.size() == 0) begin
          $error("unexpected result: order %0d overflow %0d", out_data.order, out_data.overflow);
          errors++;
        end else begin
          due = expected_orders.pop_front();
          if (out_data.order !== due.order) begin
            $error("order: expected %0d, got %0d", due.order, out_data.order);
            errors++;
          end
          if (out_data.overflow !== due.overflow) begin
            $error("overflow: expected %0d, got %0d", due.overflow, out_data.overflow);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) fold_transaction(in_data);
    end
    pending = expected_orders.size();
  end

endmodule

/* dv/version_string_compare_tb.sv */
module version_string_compare_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vsc_pkg::*;

  localparam int MAX_LEN = 64;
  localparam int PAIR_ITEMS = 600;
  localparam int HOLD_AFTER = 250;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES = 600;
  localparam logic [7:0] CHAR_DOT = 8'h2e;
  localparam logic [7:0] CHAR_DASH = 8'h2d;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  vsc_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  vsc_out_t out_data;
  int       errors;
  int       pending;

  int         sent;
  int         burst_left;
  logic [7:0] text_a [$];
  logic [7:0] text_b [$];
  logic [7:0] spare [$];

  version_string_compare #(.MAX_LEN(MAX_LEN)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  version_string_compare_checker #(.MAX_LEN(MAX_LEN)) checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one transaction and hold it until accepted; close the burst when it runs out.
  task automatic put(input logic which, input logic [7:0] sym, input logic has,
                     input logic eos);
    in_data.which_string = which;
    in_data.symbol = sym;
    in_data.has_symbol = has;
    in_data.end_of_string = eos;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
    end
  endtask

  task automatic put_text(input logic which, input string s, input logic end_on_last);
    int k;
    for (k = 0; k < s.len(); k++)
      put(which, s[k], 1'b1, end_on_last && k == s.len() - 1);
    if (!end_on_last || s.len() == 0) put(which, 8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] version_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'(CHAR_ZERO + $urandom_range(0, 9));
      4:          return CHAR_ZERO;
      5, 6:       return CHAR_DOT;
      7:          return $urandom_range(0, 1) ? CHAR_DASH : 8'(CHAR_LOWER_A + $urandom_range(0, 25));
      default:    return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Build two similar strings so the walk reaches deep, then interleave their bytes.
  task automatic run_pair();
    int   len;
    int   ia;
    int   ib;
    logic fin_a;
    logic fin_b;
    logic side;
    logic eos;
    len = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 10);
    text_a.delete();
    repeat (len) text_a.push_back(version_byte());
    text_b = text_a;
    case ($urandom_range(0, 5))
      1: if (text_b.size() > 0) text_b[$urandom_range(0, text_b.size() - 1)] = version_byte();
      2: text_b.push_back(version_byte());
      3: if (text_b.size() > 0) void'(text_b.pop_back());
      4: text_b.insert($urandom_range(0, text_b.size()), CHAR_ZERO);
      5: begin
        text_b.delete();
        repeat ($urandom_range(0, 10)) text_b.push_back(version_byte());
      end
      default: ;
    endcase
    if ($urandom_range(0, 1)) begin
      spare = text_a;
      text_a = text_b;
      text_b = spare;
    end
    ia = 0;
    ib = 0;
    fin_a = 1'b0;
    fin_b = 1'b0;
    while (!(fin_a && fin_b)) begin
      if ($urandom_range(0, 15) == 0) begin
        // noise: empty step, or traffic to a string that is already closed
        if (fin_a || fin_b)
          put(fin_b, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else
          put(1'($urandom_range(0, 1)), 8'($urandom), 1'b0, 1'b0);
      end else begin
        side = fin_a ? 1'b1 : fin_b ? 1'b0 : 1'($urandom_range(0, 1));
        if (!side) begin
          if (ia < text_a.size()) begin
            ia++;
            eos = ia == text_a.size() && $urandom_range(0, 1);
            put(1'b0, text_a[ia - 1], 1'b1, eos);
          end else begin
            eos = 1'b1;
            put(1'b0, 8'($urandom), 1'b0, 1'b1);
          end
          fin_a = eos;
        end else begin
          if (ib < text_b.size()) begin
            ib++;
            eos = ib == text_b.size() && $urandom_range(0, 1);
            put(1'b1, text_b[ib - 1], 1'b1, eos);
          end else begin
            eos = 1'b1;
            put(1'b1, 8'($urandom), 1'b0, 1'b1);
          end
          fin_b = eos;
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    sent = 0;
    burst_left = 8;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // both empty
    put_text(1'b0, "", 1'b1);
    put_text(1'b1, "", 1'b1);
    // leading zeros dropped
    put_text(1'b0, "007", 1'b1);
    put_text(1'b1, "7", 1'b0);
    // longer run is larger
    put_text(1'b1, "9", 1'b1);
    put_text(1'b0, "10", 1'b1);
    // digit run before other byte
    put_text(1'b0, "1", 1'b1);
    put_text(1'b1, "a", 1'b1);
    // unsigned byte compare at the extremes
    put(1'b0, 8'hff, 1'b1, 1'b1);
    put(1'b1, 8'h01, 1'b1, 1'b1);
    // zero byte is an ordinary non-digit
    put(1'b0, 8'h00, 1'b1, 1'b1);
    put_text(1'b1, "0", 1'b1);
    // shorter string runs out first
    put_text(1'b0, "1.2", 1'b1);
    put_text(1'b1, "1.2.0", 1'b1);
    // traffic after a string is closed is dropped
    put_text(1'b0, "x", 1'b1);
    put(1'b0, 8'h79, 1'b1, 1'b1);
    put(1'b1, 8'h55, 1'b0, 1'b0);
    put_text(1'b1, "x", 1'b1);

    while (sent < PAIR_ITEMS) run_pair();
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("version_string_compare_tb: done, clean");
    end else begin
      $display("version_string_compare_tb: done, errors");
    end
    $finish;
  end

  // Receiver: shifting stall patterns, plus one long hold-off to back the block up.
  initial begin
    int   mode;
    int   left;
    logic held;
    out_stall = 1'b0;
    mode = 0;
    left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sent >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(10, 60);
        end
        left--;
        case (mode)
          0:       out_stall = 1'b0;
          1:       out_stall = 1'($urandom_range(0, 1));
          2:       out_stall = $urandom_range(0, 7) == 0;
          default: out_stall = $urandom_range(0, 3) != 0;
        endcase
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("version_string_compare_tb: done, errors");
    $finish;
  end

endmodule
